>>> src/bme_pkg.sv
`default_nettype none
package bme_pkg;

   localparam int MAX_BINS  = 1024;
   localparam int BIN_AW    = $clog2(MAX_BINS);
   localparam int BIN_CW    = BIN_AW + 1;
   localparam int SAMPLE_W  = 32;
   localparam int SUM_W     = 38;
   localparam int TOTAL_W   = 42;
   localparam int ACC_W     = 74;
   localparam int DIV_NW    = 84;
   localparam int DIV_DW    = 20;
   localparam int DIV_CW    = $clog2(DIV_NW);
   localparam int SQ_RW     = 64;
   localparam int SQ_QW     = 32;
   localparam int SQ_CW     = $clog2(SQ_QW);
   localparam int CSR_IW    = 3;
   localparam int CSR_DW    = 16;

   localparam logic [CSR_IW-1:0] CSR_BIN_SIZE = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_NORM     = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_RESTRICT = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_FIRST    = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_LAST     = 3'd4;

   localparam logic [1:0] NORM_NONE = 2'd0;
   localparam logic [1:0] NORM_STD  = 2'd1;
   localparam logic [1:0] NORM_BOOT = 2'd2;
   localparam logic [1:0] NORM_JACK = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_SINGLE = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       final_set;
   } req_type;

   typedef struct packed {
      logic signed [31:0] mean;
      logic [31:0]        sigma;
      logic [10:0]        bins_used;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic              go;
      logic [DIV_NW-1:0] dividend;
      logic [DIV_DW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             go;
      logic [SQ_RW-1:0] radicand;
   } sqrt_req_type;

endpackage
`default_nettype wire

>>> src/bme_div.sv
`default_nettype none
module bme_div (
   input  wire                         clock,
   input  wire                         reset,
   input  wire bme_pkg::div_req_type   req,
   output logic                        done,
   output logic [bme_pkg::DIV_NW-1:0]  quotient
);
   import bme_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic [DIV_DW-1:0] rem_ff;
   logic [DIV_DW-1:0] dsr_ff;
   logic [DIV_NW-1:0] quo_ff;
   logic [DIV_DW:0]   trial;
   logic [DIV_DW:0]   diff;
   logic              ge;

   always_comb begin
      trial = {rem_ff, quo_ff[DIV_NW-1]};
      diff  = trial - {1'b0, dsr_ff};
      ge    = trial >= {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= req.dividend;
            dsr_ff  <= req.divisor;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            quo_ff <= {quo_ff[DIV_NW-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CW'(DIV_NW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

>>> src/bme_sqrt.sv
`default_nettype none
module bme_sqrt (
   input  wire                        clock,
   input  wire                        reset,
   input  wire bme_pkg::sqrt_req_type req,
   output logic                       done,
   output logic [bme_pkg::SQ_QW-1:0]  root
);
   import bme_pkg::*;

   logic             busy_ff;
   logic             done_ff;
   logic [SQ_CW-1:0] cnt_ff;
   logic [SQ_RW-1:0] rad_ff;
   logic [SQ_QW-1:0] root_ff;
   logic [SQ_QW:0]   rem_ff;
   logic [SQ_QW+2:0] part;
   logic [SQ_QW+2:0] trial;
   logic [SQ_QW+2:0] diff;
   logic             ge;

   always_comb begin
      part  = {rem_ff, rad_ff[SQ_RW-1:SQ_RW-2]};
      trial = {1'b0, root_ff, 2'b01};
      diff  = part - trial;
      ge    = part >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            root_ff <= '0;
            rad_ff  <= req.radicand;
         end else if (busy_ff) begin
            rem_ff  <= ge ? diff[SQ_QW:0] : part[SQ_QW:0];
            root_ff <= {root_ff[SQ_QW-2:0], ge};
            rad_ff  <= {rad_ff[SQ_RW-3:0], 2'b00};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == SQ_CW'(SQ_QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

>>> src/binned_mean_and_error.sv
// A sample that closes no bin and is not final leaves the sequencer idle; one that closes a bin
// waits on the 84-step shared divider. A final sample with stored bins adds one divide for the
// mean, a read, multiply and accumulate step per stored bin through the single bin store read
// port and multiplier, then a normalization divide and a square root; a lone normalized bin skips both.
// Flow: one item at a time; the result register lets the next item in while it waits.
// Reset is synchronous and active high; the bin store has no clearing pass.
`default_nettype none
module binned_mean_and_error (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire bme_pkg::req_type       req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output bme_pkg::rsp_type            rsp_data,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire [bme_pkg::CSR_IW-1:0]   csr_index,
   input  wire [bme_pkg::CSR_DW-1:0]   csr_data
);
   import bme_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE = 11'b00000000001,
      ST_BDIV = 11'b00000000010,
      ST_FIN  = 11'b00000000100,
      ST_ADIV = 11'b00000001000,
      ST_RD   = 11'b00000010000,
      ST_MUL  = 11'b00000100000,
      ST_ACC  = 11'b00001000000,
      ST_NORM = 11'b00010000000,
      ST_NDIV = 11'b00100000000,
      ST_SQRT = 11'b01000000000,
      ST_OUT  = 11'b10000000000
   } state_type;

   state_type state_ff;

   logic [6:0]  bin_size_ff;
   logic [1:0]  norm_mode_ff;
   logic        restrict_ff;
   logic [15:0] first_set_ff;
   logic [15:0] last_set_ff;

   logic signed [SUM_W-1:0]   bin_sum_ff;
   logic [6:0]                in_bin_ff;
   logic [BIN_CW-1:0]         bin_count_ff;
   logic [15:0]               set_index_ff;
   logic signed [TOTAL_W-1:0] total_ff;
   logic                      final_ff;
   logic                      neg_ff;
   logic signed [31:0]        avg_ff;
   logic [BIN_AW-1:0]         idx_ff;
   logic signed [31:0]        rd_data_ff;
   logic [63:0]               prod_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic signed [31:0]        res_mean_ff;
   logic [31:0]               res_sigma_ff;
   logic [1:0]                res_status_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;
   div_req_type               div_req_ff;
   sqrt_req_type              sqrt_req_ff;

   logic signed [31:0] bin_mem [MAX_BINS];

   logic              div_done;
   logic [DIV_NW-1:0] div_quo;
   logic              sqrt_done;
   logic [SQ_QW-1:0]  sqrt_root;

   bme_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   bme_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   logic [6:0]                size;
   logic [15:0]               idx_next;
   logic                      keep;
   logic signed [SUM_W-1:0]   sum_next;
   logic [6:0]                cnt_next;
   logic [SUM_W-1:0]          sum_abs;
   logic [TOTAL_W-1:0]        total_abs;
   logic signed [SUM_W:0]     bm_full;
   logic signed [31:0]        bmean;
   logic signed [TOTAL_W:0]   av_full;
   logic signed [32:0]        dev;
   logic [32:0]               dev_abs;
   logic [65:0]               sq;
   logic [BIN_CW-1:0]         n_m1;
   logic [2*BIN_CW-1:0]       n_prod;
   logic [ACC_W+BIN_CW-1:0]   jack;
   logic                      mem_we;
   logic                      req_xfer;
   logic                      rsp_load;
   logic                      single_bin;
   logic                      div_start;
   logic                      sqrt_start;

   always_comb begin
      priority if (bin_size_ff == 7'd0) size = 7'd1;
      else if (bin_size_ff > 7'd64)     size = 7'd64;
      else                              size = bin_size_ff;
      idx_next = (set_index_ff == 16'hFFFF) ? set_index_ff : set_index_ff + 16'd1;
      keep     = !restrict_ff || (idx_next >= first_set_ff && idx_next <= last_set_ff);
      sum_next = bin_sum_ff + SUM_W'(req_data.sample);
      cnt_next = in_bin_ff + 7'd1;
      sum_abs  = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
      total_abs = total_ff[TOTAL_W-1] ? TOTAL_W'(-total_ff) : TOTAL_W'(total_ff);
      bm_full  = neg_ff ? -$signed({1'b0, div_quo[SUM_W-1:0]})
                        : $signed({1'b0, div_quo[SUM_W-1:0]});
      priority if (bm_full > (SUM_W+1)'(32'sh7FFFFFFF)) bmean = 32'sh7FFFFFFF;
      else if (bm_full < -(SUM_W+1)'(33'sh080000000))  bmean = 32'sh80000000;
      else                                              bmean = bm_full[31:0];
      av_full  = neg_ff ? -$signed({1'b0, div_quo[TOTAL_W-1:0]})
                        : $signed({1'b0, div_quo[TOTAL_W-1:0]});
      dev      = {rd_data_ff[31], rd_data_ff} - {avg_ff[31], avg_ff};
      dev_abs  = dev[32] ? 33'(-dev) : 33'(dev);
      sq       = dev_abs * dev_abs;
      n_m1     = bin_count_ff - 1'b1;
      n_prod   = bin_count_ff * n_m1;
      jack     = acc_ff * n_m1;
      mem_we   = (state_ff == ST_BDIV) && div_done && (bin_count_ff < BIN_CW'(MAX_BINS));
      req_xfer = req_valid && req_ready;
      rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
      single_bin = (bin_count_ff == BIN_CW'(1)) && (norm_mode_ff != NORM_NONE);
      div_start  = ((state_ff == ST_IDLE) && req_xfer && keep && (cnt_next >= size))
                || ((state_ff == ST_FIN) && (bin_count_ff != '0))
                || ((state_ff == ST_NORM) && !single_bin);
      sqrt_start = (state_ff == ST_NDIV) && div_done && (div_quo[DIV_NW-1:SQ_RW] == '0);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[bin_count_ff[BIN_AW-1:0]] <= bmean;
      end
      rd_data_ff <= bin_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_size_ff  <= 7'd1;
         norm_mode_ff <= NORM_NONE;
         restrict_ff  <= 1'b0;
         first_set_ff <= 16'd1;
         last_set_ff  <= 16'hFFFF;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BIN_SIZE: bin_size_ff  <= csr_data[6:0];
            CSR_NORM:     norm_mode_ff <= csr_data[1:0];
            CSR_RESTRICT: restrict_ff  <= csr_data[0];
            CSR_FIRST:    first_set_ff <= csr_data;
            CSR_LAST:     last_set_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         bin_sum_ff     <= '0;
         in_bin_ff      <= '0;
         bin_count_ff   <= '0;
         set_index_ff   <= '0;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         div_req_ff.go  <= 1'b0;
         sqrt_req_ff.go <= 1'b0;
      end else begin
         div_req_ff.go  <= div_start;
         sqrt_req_ff.go <= sqrt_start;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  set_index_ff <= idx_next;
                  final_ff     <= req_data.final_set;
                  if (keep) begin
                     bin_sum_ff <= sum_next;
                     in_bin_ff  <= cnt_next;
                  end
                  if (keep && cnt_next >= size) begin
                     div_req_ff.dividend <= DIV_NW'(sum_abs);
                     div_req_ff.divisor  <= DIV_DW'(cnt_next);
                     neg_ff              <= sum_next[SUM_W-1];
                     state_ff            <= ST_BDIV;
                  end else if (req_data.final_set) begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_BDIV: begin
               if (div_done) begin
                  if (mem_we) begin
                     bin_count_ff <= bin_count_ff + 1'b1;
                     total_ff     <= total_ff + TOTAL_W'(bmean);
                  end
                  bin_sum_ff <= '0;
                  in_bin_ff  <= '0;
                  state_ff   <= final_ff ? ST_FIN : ST_IDLE;
               end
            end
            ST_FIN: begin
               if (bin_count_ff == '0) begin
                  res_mean_ff   <= '0;
                  res_sigma_ff  <= '0;
                  res_status_ff <= STATUS_EMPTY;
                  state_ff      <= ST_OUT;
               end else begin
                  div_req_ff.dividend <= DIV_NW'(total_abs);
                  div_req_ff.divisor  <= DIV_DW'(bin_count_ff);
                  neg_ff              <= total_ff[TOTAL_W-1];
                  state_ff            <= ST_ADIV;
               end
            end
            ST_ADIV: begin
               if (div_done) begin
                  avg_ff      <= av_full[31:0];
                  res_mean_ff <= av_full[31:0];
                  acc_ff      <= '0;
                  idx_ff      <= '0;
                  state_ff    <= ST_RD;
               end
            end
            ST_RD: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= sq[63:0];
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               acc_ff <= acc_ff + ACC_W'(prod_ff);
               if (BIN_CW'(idx_ff) + 1'b1 == bin_count_ff) begin
                  state_ff <= ST_NORM;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_RD;
               end
            end
            ST_NORM: begin
               if (single_bin) begin
                  res_sigma_ff  <= '0;
                  res_status_ff <= STATUS_SINGLE;
                  state_ff      <= ST_OUT;
               end else begin
                  res_status_ff <= STATUS_OK;
                  unique case (norm_mode_ff)
                     NORM_NONE: begin
                        div_req_ff.dividend <= DIV_NW'(acc_ff);
                        div_req_ff.divisor  <= DIV_DW'(1);
                     end
                     NORM_STD: begin
                        div_req_ff.dividend <= DIV_NW'(acc_ff);
                        div_req_ff.divisor  <= DIV_DW'(n_prod);
                     end
                     NORM_BOOT: begin
                        div_req_ff.dividend <= DIV_NW'(acc_ff);
                        div_req_ff.divisor  <= DIV_DW'(n_m1);
                     end
                     default: begin
                        div_req_ff.dividend <= DIV_NW'(jack);
                        div_req_ff.divisor  <= DIV_DW'(bin_count_ff);
                     end
                  endcase
                  state_ff <= ST_NDIV;
               end
            end
            ST_NDIV: begin
               if (div_done) begin
                  if (div_quo[DIV_NW-1:SQ_RW] != '0) begin
                     res_sigma_ff <= 32'hFFFFFFFF;
                     state_ff     <= ST_OUT;
                  end else begin
                     sqrt_req_ff.radicand <= div_quo[SQ_RW-1:0];
                     state_ff             <= ST_SQRT;
                  end
               end
            end
            ST_SQRT: begin
               if (sqrt_done) begin
                  res_sigma_ff <= sqrt_root;
                  state_ff     <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_load) begin
                  bin_sum_ff   <= '0;
                  in_bin_ff    <= '0;
                  bin_count_ff <= '0;
                  set_index_ff <= '0;
                  total_ff     <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.mean      <= res_mean_ff;
         rsp_ff.sigma     <= res_sigma_ff;
         rsp_ff.bins_used <= bin_count_ff;
         rsp_ff.status    <= res_status_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_bin_count_max: assert property (@(posedge clock) disable iff (reset)
      bin_count_ff <= BIN_CW'(MAX_BINS))
      else $error("bin count beyond store depth");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STATUS_EMPTY |->
         rsp_ff.bins_used == '0 && rsp_ff.sigma == '0)
      else $error("empty result carries bins or sigma");

   a_idle_no_divide: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_req_ff.go && !sqrt_req_ff.go)
      else $error("unit started while idle");

endmodule
`default_nettype wire

>>> tb/sv/bme_result_checker.sv
`timescale 1ns / 100ps
module bme_result_checker
   import bme_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   input  wire     req_ready,
   input  req_type req_data,
   input  wire     rsp_valid,
   input  wire     rsp_ready,
   input  rsp_type rsp_data,
   input  wire     csr_valid,
   input  wire     csr_ready,
   input  wire [CSR_IW-1:0] csr_index,
   input  wire [CSR_DW-1:0] csr_data,
   output int      fail_count,
   output int      pending_count
);

   logic [6:0]  cfg_bin_size;
   logic [1:0]  cfg_norm;
   logic        cfg_restrict;
   logic [15:0] cfg_first;
   logic [15:0] cfg_last;

   int          bin_means [MAX_BINS];
   longint      open_sum;
   int          open_count;
   int          closed_bins;
   int          set_count;
   longint      means_sum;
   rsp_type     expected_results [$];

   assign pending_count = expected_results.size();

   function automatic logic [31:0] floor_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x)
            root = trial;
      end
      return root[31:0];
   endfunction

   function automatic rsp_type point_summary();
      rsp_type     r;
      longint      avg;
      longint      dev;
      logic [63:0] mag;
      logic [127:0] acc;
      r = '0;
      r.bins_used = closed_bins[10:0];
      if (closed_bins == 0) begin
         r.status = STATUS_EMPTY;
         return r;
      end
      avg = means_sum / longint'(closed_bins);
      r.mean = avg[31:0];
      acc = '0;
      for (int k = 0; k < closed_bins; k++) begin
         dev = longint'(bin_means[k]) - avg;
         mag = dev < 0 ? 64'(-dev) : 64'(dev);
         acc = acc + 128'(mag * mag);
      end
      if (closed_bins == 1 && cfg_norm != NORM_NONE) begin
         r.status = STATUS_SINGLE;
         return r;
      end
      case (cfg_norm)
         NORM_STD: begin
            acc = acc / 128'(closed_bins * (closed_bins - 1));
         end
         NORM_BOOT: begin
            acc = acc / 128'(closed_bins - 1);
         end
         NORM_JACK: begin
            acc = acc * 128'(closed_bins - 1);
            acc = acc / 128'(closed_bins);
         end
         default: ;
      endcase
      r.status = STATUS_OK;
      r.sigma = acc[127:64] != 0 ? 32'hFFFF_FFFF : floor_sqrt(acc[63:0]);
      return r;
   endfunction

   task automatic report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %h got %h", $realtime, field, want, got);
      fail_count++;
   endtask

   task automatic take_sample(req_type item);
      int     size;
      longint m;
      logic   keep;
      size = cfg_bin_size == 0 ? 1 : (cfg_bin_size > 64 ? 64 : int'(cfg_bin_size));
      if (set_count < 65535)
         set_count++;
      keep = !cfg_restrict || (set_count >= cfg_first && set_count <= cfg_last);
      if (keep) begin
         open_sum += longint'(item.sample);
         open_count++;
         if (open_count >= size) begin
            m = open_sum / longint'(open_count);
            if (m > 64'sd2147483647) m = 64'sd2147483647;
            if (m < -64'sd2147483648) m = -64'sd2147483648;
            if (closed_bins < MAX_BINS) begin
               bin_means[closed_bins] = int'(m);
               closed_bins++;
               means_sum += m;
            end
            open_sum = 0;
            open_count = 0;
         end
      end
      if (item.final_set) begin
         expected_results = {expected_results, point_summary()};
         open_sum = 0;
         open_count = 0;
         closed_bins = 0;
         set_count = 0;
         means_sum = 0;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_bin_size <= 1;
         cfg_norm     <= NORM_NONE;
         cfg_restrict <= 0;
         cfg_first    <= 1;
         cfg_last     <= 16'hFFFF;
         open_sum = 0;
         open_count = 0;
         closed_bins = 0;
         set_count = 0;
         means_sum = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result transfer with nothing expected", $realtime);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.mean !== want.mean)
                  report("mean", want.mean, rsp_data.mean);
               if (rsp_data.sigma !== want.sigma)
                  report("sigma", want.sigma, rsp_data.sigma);
               if (rsp_data.bins_used !== want.bins_used)
                  report("bins_used", 32'(want.bins_used), 32'(rsp_data.bins_used));
               if (rsp_data.status !== want.status)
                  report("status", 32'(want.status), 32'(rsp_data.status));
            end
         end
         if (req_valid && req_ready)
            take_sample(req_data);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BIN_SIZE: cfg_bin_size <= csr_data[6:0];
               CSR_NORM:     cfg_norm     <= csr_data[1:0];
               CSR_RESTRICT: cfg_restrict <= csr_data[0];
               CSR_FIRST:    cfg_first    <= csr_data;
               CSR_LAST:     cfg_last     <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

>>> tb/sv/binned_mean_and_error_tb.sv
`timescale 1ns / 100ps
module binned_mean_and_error_tb;
   import bme_pkg::*;

   logic              clock = 0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_data;
   int                fail_count;
   int                pending_count;
   int                samples_sent;
   logic              no_gaps;

   binned_mean_and_error i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   bme_result_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int pause_len();
      if (no_gaps || $urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, 14);
   endfunction

   function automatic logic [31:0] draw_sample();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($urandom_range(0, 524280)) - 32'd262140;
      endcase
   endfunction

   task automatic send_sample(logic [31:0] value, logic last);
      int gap;
      gap = pause_len();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data.sample <= value;
      req_data.final_set <= last;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   task automatic send_point(int sets);
      for (int i = 1; i <= sets; i++)
         send_sample(draw_sample(), i == sets);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic write_all(int size, logic [1:0] norm, logic restr, int first, int last);
      write_reg(CSR_BIN_SIZE, 16'(size));
      write_reg(CSR_NORM, 16'(norm));
      write_reg(CSR_RESTRICT, 16'(restr));
      write_reg(CSR_FIRST, 16'(first));
      write_reg(CSR_LAST, 16'(last));
   endtask

   initial begin
      #40_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         int stall;
         stall = pause_len();
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int size;
      int first;
      int phase;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_valid = 0;
      csr_index = '0;
      csr_data = '0;
      no_gaps = 0;
      samples_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_sample(32'h7FFF_FFFF, 1);
      send_sample(32'h8000_0000, 0);
      send_sample(32'h7FFF_FFFF, 1);
      drain();
      write_reg(CSR_NORM, 16'(NORM_STD));
      write_reg(CSR_LAST + 3'd1, 16'hFFFF);
      send_sample(32'h0001_0000, 1);
      send_sample(32'h8000_0000, 0);
      send_sample(32'h7FFF_FFFF, 0);
      send_sample(32'h0000_0000, 1);
      drain();
      write_all(0, NORM_JACK, 0, 1, 65535);
      send_point(3);
      drain();
      write_all(127, NORM_BOOT, 0, 1, 65535);
      send_point(2);
      drain();
      write_all(4, NORM_BOOT, 1, 3, 2);
      send_point(4);
      drain();
      write_all(2, NORM_STD, 1, 65535, 65535);
      send_point(3);
      drain();
      write_all(2, NORM_NONE, 1, 2, 5);
      send_point(7);
      drain();

      phase = 0;
      while (samples_sent < 1550) begin
         no_gaps = $urandom_range(0, 4) == 0;
         if (phase == 3) begin
            write_all(1, NORM_BOOT, 0, 1, 65535);
            send_point(1030);
         end else begin
            case ($urandom_range(0, 9))
               0: size = 0;
               1: size = 64;
               2: size = 127;
               default: size = $urandom_range(1, 6);
            endcase
            first = $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(1, 12);
            write_all(size, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      first, $urandom_range(0, 5) == 0 ? 65535 : $urandom_range(1, 40));
            if (size == 0)
               size = 1;
            else if (size > 64)
               size = 64;
            repeat ($urandom_range(1, 4))
               send_point($urandom_range(1, size > 8 ? size * 2 + 3 : size * 6 + 2));
         end
         drain();
         phase++;
      end

      no_gaps = 0;
      drain();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
